### rtl/word_frequency_counter_unit_defines.svh
// Assertion macros shared by the checker of the word frequency counter.
`ifndef WORD_FREQUENCY_COUNTER_UNIT_DEFINES_SVH
`define WORD_FREQUENCY_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wfc_pkg.sv
// Types, constants and helper functions of the word frequency counter.
package wfc_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int MAX_LETTERS = 64;

    localparam int CHAR_W = 8;
    localparam int ENT_W  = 5;
    localparam int POS_W  = 6;
    localparam int LEN_W  = 7;
    localparam int CNT_W  = 16;
    localparam int NUM_W  = 6;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    localparam logic [CHAR_W-1:0] APOSTROPHE = 8'h27;
    localparam logic [CHAR_W-1:0] LOWER_BIT  = 8'h20;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_TEXT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] RES_WORD    = 2'd0;
    localparam logic [KIND_W-1:0] RES_SUMMARY = 2'd1;
    localparam logic [KIND_W-1:0] RES_READ    = 2'd2;

    // Sentence status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    typedef enum logic [1:0] {
        MODE_BETWEEN,
        MODE_LETTERS,
        MODE_DIGITS
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_APP,
        S_CMP,
        S_FIN,
        S_SUM,
        S_RDW,
        S_EMIT
    } t_state;

    // Broadcast control from the sequencer to every cell of the table.
    typedef struct packed {
        logic              match_clr;
        logic              cmp_en;
        logic [CHAR_W-1:0] cmp_char;
        logic [POS_W-1:0]  addr;
        logic [CHAR_W-1:0] wr_data;
        logic [LEN_W-1:0]  new_len;
    } t_cell_ctl;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

### rtl/word_frequency_counter_unit.sv
// Top level of the word frequency counter: scanner, sequencer and a row of table cells.
//
//  Port group   Direction  tuser        tdata
//  s_axis_*     in         kind         char_code, read_entry, read_position
//  m_axis_*     out        result_kind  hit_entry .. word_length
//
// A byte that stores a character passes through S_APP and then S_CMP, as the cell text
// memories have a registered read port; a letter after a held apostrophe stores both.
// i_rst_n is synchronous and active low; the table is cleared by the first text byte.
// A stalled result holds in the output register; input is taken only while the sequencer idles.
module word_frequency_counter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // char_code[7:0], read_entry[12:8], read_position[18:13]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // hit_entry[4:0], occurrences[20:5], is_new[21],
                                        // status[23:22], distinct_words[29:24],
                                        // text_byte[37:30], word_length[44:38]
    output logic [1:0]  m_axis_tuser    // result_kind[1:0]
);
    import wfc_pkg::*;

    // Control state.
    t_state            r_state, n_state;
    t_mode             r_mode, n_mode;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic              r_apos, n_apos;
    logic              r_over, n_over;
    logic [NUM_W-1:0]  r_stored, n_stored;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_open, n_open;
    logic              r_pend, n_pend;
    logic              r_pend_apos, n_pend_apos;
    logic              r_quiet, n_quiet;
    logic              r_m_valid;

    // Payload state.
    logic [KIND_W-1:0] r_kind;
    logic [CHAR_W-1:0] r_char;
    logic [ENT_W-1:0]  r_entry;
    logic [POS_W-1:0]  r_pos;
    logic [CHAR_W-1:0] r_pend_ch, n_pend_ch;
    logic [CHAR_W-1:0] r_cmp_ch, n_cmp_ch;
    logic [KIND_W-1:0] r_res_kind, n_res_kind;
    logic [ENT_W-1:0]  r_res_hit, n_res_hit;
    logic [CNT_W-1:0]  r_res_occ, n_res_occ;
    logic              r_res_new, n_res_new;
    logic [STAT_W-1:0] r_res_stat, n_res_stat;
    logic [NUM_W-1:0]  r_res_dist, n_res_dist;
    logic [CHAR_W-1:0] r_res_text, n_res_text;
    logic [LEN_W-1:0]  r_res_len, n_res_len;
    logic [47:0]       r_m_data;
    logic [1:0]        r_m_user;

    // Cell row signals.
    t_cell_ctl         cell_ctl;
    logic              wr_en, new_en, inc_en;
    logic              cell_match [MAX_ENTRIES];
    logic [LEN_W-1:0]  cell_len   [MAX_ENTRIES];
    logic [CNT_W-1:0]  cell_cnt   [MAX_ENTRIES];
    logic [CHAR_W-1:0] cell_rdata [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] wr_sel, new_sel, inc_sel, hit_vec;
    logic              any_hit;
    logic [ENT_W-1:0]  hit_idx;
    logic [CNT_W-1:0]  hit_cnt, hit_cnt_inc;
    logic              table_full;
    logic              rd_ok;
    logic              accept, out_load;
    logic [CHAR_W-1:0] app_char;
    logic [CHAR_W-1:0] in_char;

    assign in_char    = s_axis_tdata[7:0];
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign table_full = (r_stored >= NUM_W'(MAX_ENTRIES));
    assign app_char   = r_pend_apos ? APOSTROPHE : r_pend_ch;
    assign rd_ok      = ({1'b0, r_entry} < r_stored);

    // Row of cells and their select lines.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        assign wr_sel[g]  = wr_en && !table_full && (r_stored == NUM_W'(g));
        assign new_sel[g] = new_en && (r_stored == NUM_W'(g));
        assign inc_sel[g] = inc_en && hit_vec[g];
        assign hit_vec[g] = cell_match[g] && (NUM_W'(g) < r_stored)
                            && (cell_len[g] == r_fill);

        wfc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (cell_ctl),
            .i_wr_sel  (wr_sel[g]),
            .i_new_sel (new_sel[g]),
            .i_inc_sel (inc_sel[g]),
            .o_match   (cell_match[g]),
            .o_len     (cell_len[g]),
            .o_cnt     (cell_cnt[g]),
            .o_rdata   (cell_rdata[g])
        );
    end

    // Entries hold distinct words, so at most one cell hits: encode by OR.
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (hit_vec[i]) begin
                hit_idx = hit_idx | ENT_W'(i);
            end
        end
        any_hit     = |hit_vec;
        hit_cnt     = cell_cnt[hit_idx];
        hit_cnt_inc = (hit_cnt == {CNT_W{1'b1}}) ? hit_cnt : hit_cnt + CNT_W'(1);
    end

    // Sequencer: next state, cell control and staged result.
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_fill      = r_fill;
        n_apos      = r_apos;
        n_over      = r_over;
        n_stored    = r_stored;
        n_status    = r_status;
        n_open      = r_open;
        n_pend      = r_pend;
        n_pend_apos = r_pend_apos;
        n_pend_ch   = r_pend_ch;
        n_quiet     = r_quiet;
        n_cmp_ch    = r_cmp_ch;
        n_res_kind  = r_res_kind;
        n_res_hit   = r_res_hit;
        n_res_occ   = r_res_occ;
        n_res_new   = r_res_new;
        n_res_stat  = r_res_stat;
        n_res_dist  = r_res_dist;
        n_res_text  = r_res_text;
        n_res_len   = r_res_len;
        wr_en       = 1'b0;
        new_en      = 1'b0;
        inc_en      = 1'b0;
        out_load    = 1'b0;

        cell_ctl.match_clr = 1'b0;
        cell_ctl.cmp_en    = 1'b0;
        cell_ctl.cmp_char  = r_cmp_ch;
        cell_ctl.addr      = (r_state == S_DECODE) ? r_pos : r_fill[POS_W-1:0];
        cell_ctl.wr_data   = app_char;
        cell_ctl.new_len   = r_fill;

        s_axis_tready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                case (r_kind)
                    KIND_TEXT: begin
                        if (!r_open) begin
                            // First byte of a sentence empties the table.
                            n_stored           = '0;
                            n_status           = ST_OK;
                            n_fill             = '0;
                            n_mode             = MODE_BETWEEN;
                            n_apos             = 1'b0;
                            n_over             = 1'b0;
                            cell_ctl.match_clr = 1'b1;
                            n_open             = 1'b1;
                        end else if (r_status != ST_OK) begin
                            n_state = S_IDLE;
                        end else begin
                            n_state   = S_IDLE;
                            n_quiet   = 1'b0;
                            n_pend    = 1'b0;
                            n_pend_ch = r_char;
                            case (r_mode)
                                MODE_LETTERS: begin
                                    if (is_letter(r_char)) begin
                                        n_pend      = 1'b1;
                                        n_pend_apos = r_apos;
                                        n_pend_ch   = r_char | LOWER_BIT;
                                        n_apos      = 1'b0;
                                        n_state     = S_APP;
                                    end else if (r_char == APOSTROPHE) begin
                                        if (r_apos) begin
                                            n_status           = ST_INVALID;
                                            n_fill             = '0;
                                            n_mode             = MODE_BETWEEN;
                                            n_apos             = 1'b0;
                                            n_over             = 1'b0;
                                            cell_ctl.match_clr = 1'b1;
                                        end else begin
                                            n_apos = 1'b1;
                                        end
                                    end else if (is_digit(r_char)) begin
                                        if (r_apos) begin
                                            // Word ends; the digit then starts a number.
                                            n_pend      = 1'b1;
                                            n_pend_apos = 1'b0;
                                            n_state     = S_FIN;
                                        end else begin
                                            n_status           = ST_INVALID;
                                            n_fill             = '0;
                                            n_mode             = MODE_BETWEEN;
                                            n_apos             = 1'b0;
                                            n_over             = 1'b0;
                                            cell_ctl.match_clr = 1'b1;
                                        end
                                    end else begin
                                        n_state = S_FIN;
                                    end
                                end
                                MODE_DIGITS: begin
                                    if (is_digit(r_char)) begin
                                        n_pend      = 1'b1;
                                        n_pend_apos = 1'b0;
                                        n_state     = S_APP;
                                    end else if (is_letter(r_char)) begin
                                        n_status           = ST_INVALID;
                                        n_fill             = '0;
                                        n_mode             = MODE_BETWEEN;
                                        n_apos             = 1'b0;
                                        n_over             = 1'b0;
                                        cell_ctl.match_clr = 1'b1;
                                    end else begin
                                        n_state = S_FIN;
                                    end
                                end
                                default: begin
                                    if (is_letter(r_char)) begin
                                        n_mode      = MODE_LETTERS;
                                        n_pend      = 1'b1;
                                        n_pend_apos = 1'b0;
                                        n_pend_ch   = r_char | LOWER_BIT;
                                        n_state     = S_APP;
                                    end else if (is_digit(r_char)) begin
                                        n_mode      = MODE_DIGITS;
                                        n_pend      = 1'b1;
                                        n_pend_apos = 1'b0;
                                        n_state     = S_APP;
                                    end
                                end
                            endcase
                        end
                    end

                    KIND_END: begin
                        n_pend  = 1'b0;
                        n_quiet = 1'b1;
                        n_state = S_SUM;
                        if (!r_open) begin
                            n_stored = '0;
                            n_status = ST_OK;
                        end else if (r_status == ST_OK && r_mode != MODE_BETWEEN) begin
                            n_state = S_FIN;
                        end
                    end

                    KIND_READ: begin
                        n_pend  = 1'b0;
                        n_state = S_RDW;
                    end

                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            // Store one character: write it to the free cell and read every cell, or mark the word too long.
            S_APP: begin
                if (r_pend_apos) begin
                    n_pend_apos = 1'b0;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_fill < LEN_W'(MAX_LETTERS)) begin
                    wr_en    = 1'b1;
                    n_cmp_ch = app_char;
                    n_fill   = r_fill + LEN_W'(1);
                    n_state  = S_CMP;
                end else begin
                    n_over  = 1'b1;
                    n_state = r_pend_apos ? S_APP : S_IDLE;
                end
            end

            // Update the match flags with the character just read back.
            S_CMP: begin
                cell_ctl.cmp_en = 1'b1;
                n_state         = r_pend ? S_APP : S_IDLE;
            end

            // Count the finished word, or drop it and set the status if it is too long or the table is full.
            S_FIN: begin
                n_fill             = '0;
                n_mode             = MODE_BETWEEN;
                n_apos             = 1'b0;
                n_over             = 1'b0;
                cell_ctl.match_clr = 1'b1;
                n_res_kind         = RES_WORD;
                n_res_stat         = ST_OK;
                n_res_text         = '0;
                n_res_len          = r_fill;
                if (r_over || (!any_hit && table_full)) begin
                    n_status = r_over ? ST_TOO_LONG : ST_FULL;
                    n_pend   = 1'b0;
                    n_state  = r_quiet ? S_SUM : S_IDLE;
                end else begin
                    if (any_hit) begin
                        inc_en     = 1'b1;
                        n_res_hit  = hit_idx;
                        n_res_occ  = hit_cnt_inc;
                        n_res_new  = 1'b0;
                        n_res_dist = r_stored;
                    end else begin
                        new_en     = 1'b1;
                        n_stored   = r_stored + NUM_W'(1);
                        n_res_hit  = r_stored[ENT_W-1:0];
                        n_res_occ  = CNT_W'(1);
                        n_res_new  = 1'b1;
                        n_res_dist = r_stored + NUM_W'(1);
                    end
                    if (r_pend) begin
                        n_mode = MODE_DIGITS;
                    end
                    n_state = r_quiet ? S_SUM : S_EMIT;
                end
            end

            // Close the sentence and stage its summary.
            S_SUM: begin
                n_fill             = '0;
                n_mode             = MODE_BETWEEN;
                n_apos             = 1'b0;
                n_over             = 1'b0;
                cell_ctl.match_clr = 1'b1;
                n_open             = 1'b0;
                n_res_kind         = RES_SUMMARY;
                n_res_hit          = '0;
                n_res_occ          = '0;
                n_res_new          = 1'b0;
                n_res_stat         = r_status;
                n_res_dist         = r_stored;
                n_res_text         = '0;
                n_res_len          = '0;
                n_state            = S_EMIT;
            end

            // Read data of the selected cell is valid now.
            S_RDW: begin
                n_res_kind = RES_READ;
                n_res_hit  = r_entry;
                n_res_occ  = rd_ok ? cell_cnt[r_entry] : '0;
                n_res_new  = 1'b0;
                n_res_stat = r_status;
                n_res_dist = r_stored;
                n_res_len  = rd_ok ? cell_len[r_entry] : '0;
                n_res_text = (rd_ok && ({1'b0, r_pos} < cell_len[r_entry]))
                             ? cell_rdata[r_entry] : '0;
                n_state    = S_EMIT;
            end

            // Hand the staged result to the output register once it is free.
            S_EMIT: begin
                if (!r_m_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = r_pend ? S_APP : S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_BETWEEN;
            r_fill      <= '0;
            r_apos      <= 1'b0;
            r_over      <= 1'b0;
            r_stored    <= '0;
            r_status    <= ST_OK;
            r_open      <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_apos <= 1'b0;
            r_quiet     <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_fill      <= n_fill;
            r_apos      <= n_apos;
            r_over      <= n_over;
            r_stored    <= n_stored;
            r_status    <= n_status;
            r_open      <= n_open;
            r_pend      <= n_pend;
            r_pend_apos <= n_pend_apos;
            r_quiet     <= n_quiet;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers: the captured transaction, staged result and output data.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= s_axis_tuser;
            r_char  <= in_char;
            r_entry <= s_axis_tdata[12:8];
            r_pos   <= s_axis_tdata[18:13];
        end
        r_pend_ch  <= n_pend_ch;
        r_cmp_ch   <= n_cmp_ch;
        r_res_kind <= n_res_kind;
        r_res_hit  <= n_res_hit;
        r_res_occ  <= n_res_occ;
        r_res_new  <= n_res_new;
        r_res_stat <= n_res_stat;
        r_res_dist <= n_res_dist;
        r_res_text <= n_res_text;
        r_res_len  <= n_res_len;
        if (out_load) begin
            r_m_user <= r_res_kind;
            r_m_data <= {3'b000, r_res_len, r_res_text, r_res_dist, r_res_stat,
                         r_res_new, r_res_occ, r_res_hit};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

### rtl/wfc_cell.sv
// One table cell: the text, length and count of one distinct word, plus its match flag.
module wfc_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wfc_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_wr_sel,
    input  logic                          i_new_sel,
    input  logic                          i_inc_sel,
    output logic                          o_match,
    output logic [wfc_pkg::LEN_W-1:0]     o_len,
    output logic [wfc_pkg::CNT_W-1:0]     o_cnt,
    output logic [wfc_pkg::CHAR_W-1:0]    o_rdata
);
    import wfc_pkg::*;

    logic [CHAR_W-1:0] r_mem [MAX_LETTERS];
    logic [CHAR_W-1:0] r_rdata;
    logic              r_match;
    logic [LEN_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_cnt;

    // Text memory: one write port for the word being scanned, one registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_sel) begin
            r_mem[i_ctl.addr] <= i_ctl.wr_data;
        end
        r_rdata <= r_mem[i_ctl.addr];
    end

    // The match flag says the stored text starts with every character scanned so far.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b1;
        end else if (i_ctl.match_clr) begin
            r_match <= 1'b1;
        end else if (i_ctl.cmp_en) begin
            r_match <= r_match & (r_rdata == i_ctl.cmp_char);
        end
    end

    // Length and saturating count of the entry.
    always_ff @(posedge i_clk) begin
        if (i_new_sel) begin
            r_len <= i_ctl.new_len;
            r_cnt <= CNT_W'(1);
        end else if (i_inc_sel && (r_cnt != {CNT_W{1'b1}})) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_match = r_match;
    assign o_len   = r_len;
    assign o_cnt   = r_cnt;
    assign o_rdata = r_rdata;

endmodule

### rtl/wfc_checker.sv
// Port-level checker of the word frequency counter and its bind to the top level.
`include "word_frequency_counter_unit_defines.svh"

module wfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import wfc_pkg::*;

    // A stalled result keeps its payload.
    `WFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    // One transaction at a time: input is closed in the cycle after an accept.
    `WFC_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted twice in a row")

    // A summary carries no entry, count, text or length.
    `WFC_ASSERT_NOW(a_sum_clean, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == RES_SUMMARY, m_axis_tdata[21:0] == 22'd0 && m_axis_tdata[47:30] == 18'd0, "summary has stray fields")

    // A counted word reports ok status, a nonzero count and at least one stored word.
    `WFC_ASSERT_NOW(a_word_ok, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == RES_WORD, m_axis_tdata[23:22] == ST_OK && m_axis_tdata[20:5] != 16'd0 && m_axis_tdata[29:24] != 6'd0 && m_axis_tdata[37:30] == 8'd0, "bad word result")

endmodule

bind word_frequency_counter_unit wfc_checker u_wfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### test/tb_word_frequency_counter_unit.sv
// Self-checking testbench of the word frequency counter: random sentences against a predictor.
module tb_word_frequency_counter_unit;
    import wfc_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int ITEMS_PER_PHASE = 570;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // char_code[7:0], read_entry[12:8], read_position[18:13]
    logic [1:0]  s_axis_tuser;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // hit_entry[4:0], occurrences[20:5], is_new[21], status[23:22],
                                 // distinct_words[29:24], text_byte[37:30], word_length[44:38]
    logic [1:0]  m_axis_tuser;   // result_kind[1:0]

    // One expected result.
    typedef struct {
        logic [KIND_W-1:0] rkind;
        logic [ENT_W-1:0]  entry;
        logic [CNT_W-1:0]  occ;
        logic              fresh;
        logic [STAT_W-1:0] stat;
        logic [NUM_W-1:0]  words;
        logic [CHAR_W-1:0] text;
        logic [LEN_W-1:0]  len;
    } t_expect;

    // Word table predictor and the store of expected results.
    class word_table_scoreboard;
        logic [CHAR_W-1:0] tab_text [MAX_ENTRIES][MAX_LETTERS];
        logic [LEN_W-1:0]  tab_len [MAX_ENTRIES];
        logic [CNT_W-1:0]  tab_cnt [MAX_ENTRIES];
        logic [CHAR_W-1:0] word_chars [MAX_LETTERS];
        int                fill;
        t_mode             mode;
        bit                held_apos;
        bit                too_long;
        int                nwords;
        logic [STAT_W-1:0] stat;
        bit                open;
        t_expect           pending_results [$];
        int                mismatches;
        int                words_seen;
        int                summaries_seen;
        int                reads_seen;

        function new();
            fill = 0; mode = MODE_BETWEEN; held_apos = 0; too_long = 0;
            nwords = 0; stat = ST_OK; open = 0; mismatches = 0;
            words_seen = 0; summaries_seen = 0; reads_seen = 0;
        endfunction

        function bit alpha(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function bit numeral(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        function void drop_word();
            fill = 0; mode = MODE_BETWEEN; held_apos = 0; too_long = 0;
        endfunction

        function void push_char(logic [7:0] c);
            if (fill < MAX_LETTERS) begin
                word_chars[fill] = c;
                fill++;
            end else begin
                too_long = 1;
            end
        endfunction

        function void add_result(logic [1:0] k, int e, logic [15:0] o, bit f,
                                 logic [1:0] s, logic [7:0] t, int l);
            t_expect x;
            x.rkind = k; x.entry = e[4:0]; x.occ = o; x.fresh = f; x.stat = s;
            x.words = nwords[5:0]; x.text = t; x.len = l[6:0];
            pending_results.push_back(x);
        endfunction

        // Matches the scanned word against the table, counting or storing it.
        function void count_word(bit emit);
            int i;
            bit same;
            bit fresh;
            fresh = 0;
            if (too_long) begin
                stat = ST_TOO_LONG;
                drop_word();
                return;
            end
            for (i = 0; i < nwords; i++) begin
                same = (tab_len[i] == fill);
                for (int j = 0; j < fill && same; j++)
                    if (tab_text[i][j] != word_chars[j]) same = 0;
                if (same) break;
            end
            if (i < nwords) begin
                if (tab_cnt[i] != 16'hFFFF) tab_cnt[i]++;
            end else begin
                if (nwords >= MAX_ENTRIES) begin
                    stat = ST_FULL;
                    drop_word();
                    return;
                end
                for (int j = 0; j < fill; j++) tab_text[i][j] = word_chars[j];
                tab_len[i] = fill[6:0];
                tab_cnt[i] = 16'd1;
                nwords++;
                fresh = 1;
            end
            if (emit) add_result(RES_WORD, i, tab_cnt[i], fresh, ST_OK, 8'h00, fill);
            drop_word();
        endfunction

        function void start_sentence();
            nwords = 0; stat = ST_OK; drop_word(); open = 1;
        endfunction

        function void take_char(logic [7:0] c);
            if (!open) start_sentence();
            if (stat != ST_OK) return;
            case (mode)
                MODE_LETTERS: begin
                    if (alpha(c)) begin
                        if (held_apos) push_char(APOSTROPHE);
                        held_apos = 0;
                        push_char(c | LOWER_BIT);
                    end else if (c == APOSTROPHE) begin
                        if (held_apos) begin
                            stat = ST_INVALID; drop_word();
                        end else begin
                            held_apos = 1;
                        end
                    end else if (numeral(c)) begin
                        if (held_apos) begin
                            count_word(1);
                            if (stat == ST_OK) begin
                                mode = MODE_DIGITS;
                                push_char(c);
                            end
                        end else begin
                            stat = ST_INVALID; drop_word();
                        end
                    end else begin
                        count_word(1);
                    end
                end
                MODE_DIGITS: begin
                    if (numeral(c)) push_char(c);
                    else if (alpha(c)) begin
                        stat = ST_INVALID; drop_word();
                    end else count_word(1);
                end
                default: begin
                    if (alpha(c)) begin
                        mode = MODE_LETTERS; push_char(c | LOWER_BIT);
                    end else if (numeral(c)) begin
                        mode = MODE_DIGITS; push_char(c);
                    end
                end
            endcase
        endfunction

        // Notes one accepted input transaction.
        function void note_item(logic [1:0] k, logic [7:0] c, logic [4:0] e, logic [5:0] p);
            int l;
            logic [15:0] o;
            logic [7:0] t;
            if (k == KIND_TEXT) begin
                take_char(c);
            end else if (k == KIND_END) begin
                if (!open) start_sentence();
                else if (stat == ST_OK && mode != MODE_BETWEEN) count_word(0);
                drop_word();
                open = 0;
                add_result(RES_SUMMARY, 0, 16'h0, 0, stat, 8'h00, 0);
            end else if (k == KIND_READ) begin
                l = 0; o = 0; t = 0;
                if (e < nwords) begin
                    l = tab_len[e];
                    o = tab_cnt[e];
                    if (p < l) t = tab_text[e][p];
                end
                add_result(RES_READ, e, o, 0, stat, t, l);
            end
        endfunction

        function void report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch in %s: got %0h, expected %0h", what, got, want);
        endfunction

        // Checks one accepted output transaction against the oldest expectation.
        function void check_result(logic [1:0] u, logic [47:0] d);
            t_expect x;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result kind", u, 0);
                return;
            end
            x = pending_results.pop_front();
            if (u == RES_WORD) words_seen++;
            else if (u == RES_SUMMARY) summaries_seen++;
            else reads_seen++;
            if (u != x.rkind) report_mismatch("result_kind", u, x.rkind);
            if (d[4:0] != x.entry) report_mismatch("hit_entry", d[4:0], x.entry);
            if (d[20:5] != x.occ) report_mismatch("occurrences", d[20:5], x.occ);
            if (d[21] != x.fresh) report_mismatch("is_new", d[21], x.fresh);
            if (d[23:22] != x.stat) report_mismatch("status", d[23:22], x.stat);
            if (d[29:24] != x.words) report_mismatch("distinct_words", d[29:24], x.words);
            if (d[37:30] != x.text) report_mismatch("text_byte", d[37:30], x.text);
            if (d[44:38] != x.len) report_mismatch("word_length", d[44:38], x.len);
        endfunction
    endclass

    word_table_scoreboard board;
    int  phase;
    int  items_sent;
    int  cycles;
    bit  pressure_done;
    int  hold_left;

    word_frequency_counter_unit DUT (.*);

    // Clock.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver readiness, with one long hold-off to back the block up.
    always @(negedge i_clk) begin
        if (!pressure_done && items_sent > 120) begin
            pressure_done = 1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else if (phase == 0) begin
            m_axis_tready = ($urandom_range(99) >= 63);
        end else if (phase == 1) begin
            m_axis_tready = ($urandom_range(99) >= 27);
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Offers one input transaction and waits for its acceptance.
    task automatic send_item(logic [1:0] k, logic [7:0] c, logic [4:0] e, logic [5:0] p);
        int gap;
        gap = (phase == 0) ? 27 : (phase == 1) ? 63 : 0;
        while ($urandom_range(99) < gap) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = k;
        s_axis_tdata  = {5'b0, p, e, c};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_item(k, c, e, p);
        items_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(KIND_TEXT, s[i], 5'($urandom), 6'($urandom));
    endtask

    task automatic send_read();
        send_item(KIND_READ, 8'($urandom), 5'($urandom_range(31)), 6'($urandom_range(63)));
    endtask

    // A byte that separates words.
    task automatic send_gap();
        logic [7:0] c;
        int r;
        r = $urandom_range(9);
        if (r < 6) c = " ";
        else if (r < 8) c = (r == 6) ? "," : ".";
        else begin
            c = 8'($urandom);
            while (board.alpha(c) || board.numeral(c) || c == APOSTROPHE) c = 8'($urandom);
        end
        send_item(KIND_TEXT, c, 5'($urandom), 6'($urandom));
    endtask

    // A letter word from a small alphabet, so that words repeat.
    task automatic send_letters(int n, bit apos);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = 8'(32'h61 + $urandom_range(3));
            if ($urandom_range(1)) c = c & ~LOWER_BIT;
            send_item(KIND_TEXT, c, 5'($urandom), 6'($urandom));
            if (apos && i == 0 && n > 1)
                send_item(KIND_TEXT, APOSTROPHE, 5'($urandom), 6'($urandom));
        end
    endtask

    // One random sentence: mostly well-formed words with occasional breakage.
    task automatic send_sentence();
        int nw, r;
        if ($urandom_range(15) == 0) begin
            // Enough distinct words to overflow the table.
            for (int w = 0; w < 34; w++) begin
                send_item(KIND_TEXT, 8'(32'h61 + w % 26), 5'($urandom), 6'($urandom));
                send_item(KIND_TEXT, 8'(32'h61 + w / 26), 5'($urandom), 6'($urandom));
                send_item(KIND_TEXT, " ", 5'($urandom), 6'($urandom));
            end
        end
        nw = $urandom_range(1, 12);
        for (int w = 0; w < nw; w++) begin
            r = $urandom_range(99);
            if (r < 60) send_letters($urandom_range(1, 4), 0);
            else if (r < 70) send_letters($urandom_range(2, 4), 1);
            else if (r < 75) begin
                send_letters($urandom_range(1, 3), 0);
                send_item(KIND_TEXT, APOSTROPHE, 5'($urandom), 6'($urandom));
            end else if (r < 85) begin
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    send_item(KIND_TEXT, 8'(32'h30 + $urandom_range(9)),
                              5'($urandom), 6'($urandom));
            end else if (r < 88) send_text("x''y");
            else if (r < 90) send_text("b7");
            else if (r < 92) send_text("4q");
            else if (r < 94) send_text("c'5");
            else if (r < 95) send_letters($urandom_range(64, 67), 0);
            else if (r < 97) send_read();
            else if (r < 98) send_item(KIND_UNUSED, 8'($urandom), 5'($urandom), 6'($urandom));
            else send_item(KIND_TEXT, 8'($urandom), 5'($urandom), 6'($urandom));
            if ($urandom_range(9) != 0) send_gap();
        end
        send_item(KIND_END, 8'($urandom), 5'($urandom), 6'($urandom));
        for (int i = $urandom_range(0, 4); i > 0; i--) send_read();
    endtask

    initial begin
        board = new();
        phase = 0; items_sent = 0; cycles = 0; pressure_done = 0; hold_left = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_TEXT;
        m_axis_tready = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: mixed case, inner and trailing apostrophes, apostrophe then digit.
        send_text("Don't 42 dOn'T a'7 b' ");
        send_item(KIND_END, 8'hFF, 5'd31, 6'd63);
        send_item(KIND_READ, 8'h00, 5'd0, 6'd0);
        send_item(KIND_READ, 8'h00, 5'd0, 6'd63);
        send_item(KIND_READ, 8'h00, 5'd31, 6'd0);
        // An end with no text, and an ignored item kind.
        send_item(KIND_END, 8'h00, 5'd0, 6'd0);
        send_item(KIND_UNUSED, 8'hFF, 5'd31, 6'd63);

        for (phase = 0; phase < 3; phase++) begin
            while (items_sent < (phase + 1) * ITEMS_PER_PHASE) send_sentence();
        end
        phase = 2;

        // Reads after the last sentence has closed.
        send_item(KIND_READ, 8'h00, 5'd0, 6'd0);
        send_item(KIND_END, 8'h00, 5'd0, 6'd0);
        send_item(KIND_READ, 8'h00, 5'd0, 6'd1);

        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d items sent; %0d word, %0d summary and %0d read results checked.",
                 items_sent, board.words_seen, board.summaries_seen, board.reads_seen);
        $display("Covered apostrophes, invalid and overlong words, full tables and stalls.");
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
